// File: rtl/core/round_robin_task_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// round robin task scheduler assertion macros
// concurrent assertion shorthands clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH

// consequent in the same cycle
`define RRTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// consequent in the next cycle
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// File: rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// types and constants of the round robin task scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W      = 3;

  localparam logic [7:0] QUANTUM_RST = 8'd4;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_IDLE     = 2'd2,
    ST_RAN      = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ARRIVAL = 1'b0,
    KIND_TICK    = 1'b1
  } kind_e;

  typedef enum logic {
    REG_QUANTUM         = 1'b0,
    REG_SWITCH_OVERHEAD = 1'b1
  } reg_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] tick_time;
    logic [15:0] running_id;
    logic [15:0] running_left;
    logic        running_done;
    logic        retired_valid;
    logic [15:0] retired_id;
    logic [31:0] retired_response;
    logic [31:0] overhead_sum;
    logic [31:0] response_total;
    logic [15:0] finished_count;
    logic        all_idle;
  } res_t;

endpackage

// File: rtl/core/round_robin_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// time-sliced round robin scheduler, new tasks ahead of preempted ones
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   kind, task_id, work_ticks
// out      output     out_valid_o / out_stall_i status ... all_idle
// cfg      input      apb write / read          quantum, switch_overhead
//
// one item per cycle while in_stall_o is low: the scheduler state and both queues
// update in the accepting cycle and the result is registered in the output register
// a skid register holds one more result, so a stalled output still takes one item
// in_stall_o rises only while the skid register is full
// reset clears all control state; queue entries are not cleared
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [15:0]                task_id_i,
  input  logic [15:0]                work_ticks_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [31:0]                tick_time_o,
  output logic [15:0]                running_id_o,
  output logic [15:0]                running_left_o,
  output logic                       running_done_o,
  output logic                       retired_valid_o,
  output logic [15:0]                retired_id_o,
  output logic [31:0]                retired_response_o,
  output logic [31:0]                overhead_sum_o,
  output logic [31:0]                response_total_o,
  output logic [15:0]                finished_count_o,
  output logic                       all_idle_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rrts_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned DEPTH = rrts_pkg::QUEUE_DEPTH;
  localparam int unsigned CNT_W = rrts_pkg::CNT_W;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic rrts_pkg::ptr_t wrap_add(input rrts_pkg::ptr_t p, input rrts_pkg::cnt_t c);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(p) + (CNT_W+1)'(c);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[rrts_pkg::PTR_W-1:0];
  endfunction

  function automatic rrts_pkg::ptr_t ptr_inc(input rrts_pkg::ptr_t p);
    return (p == rrts_pkg::PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // configuration
  logic [7:0] quantum_q, switch_overhead_q;
  logic       cfg_we;

  // queues
  logic [15:0] fresh_ids_q       [DEPTH];
  logic [15:0] fresh_remaining_q [DEPTH];
  logic [31:0] fresh_arrival_q   [DEPTH];
  logic [15:0] again_ids_q       [DEPTH];
  logic [15:0] again_remaining_q [DEPTH];
  logic [31:0] again_response_q  [DEPTH];

  rrts_pkg::ptr_t fresh_head_q, fresh_head_d, again_head_q, again_head_d;
  rrts_pkg::cnt_t fresh_count_q, fresh_count_d, again_count_q, again_count_d;
  rrts_pkg::ptr_t fresh_tail, again_tail;
  logic           fresh_we, again_we;

  // cpu and totals
  logic        cpu_busy_q, cpu_busy_d;
  logic [15:0] cpu_id_q, cpu_id_d;
  logic [15:0] cpu_left_q, cpu_left_d;
  logic [31:0] cpu_response_q, cpu_response_d;
  logic [7:0]  slice_left_q, slice_left_d;
  logic [31:0] now_time_q, now_time_d;
  logic [31:0] overhead_acc_q, overhead_acc_d;
  logic [31:0] response_acc_q, response_acc_d;
  logic [15:0] finished_acc_q, finished_acc_d;

  // output register and skid register
  rrts_pkg::res_t res, out_q, skid_q;
  logic           out_valid_q, skid_valid_q;
  logic           in_fire, out_free;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign fresh_tail = wrap_add(fresh_head_q, fresh_count_q);
  assign again_tail = wrap_add(again_head_q, again_count_q);

  // apb port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (rrts_pkg::reg_e'(paddr[2])) 
      rrts_pkg::REG_QUANTUM:         prdata = {24'd0, quantum_q};
      rrts_pkg::REG_SWITCH_OVERHEAD: prdata = {24'd0, switch_overhead_q};
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q         <= rrts_pkg::QUANTUM_RST;
      switch_overhead_q <= '0;
    end else if (cfg_we) begin
      unique case (rrts_pkg::reg_e'(paddr[2]))
        rrts_pkg::REG_QUANTUM:         quantum_q         <= pwdata[7:0];
        rrts_pkg::REG_SWITCH_OVERHEAD: switch_overhead_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // scheduler step
  always_comb begin
    logic [CNT_W:0] used;
    logic [7:0]     ts;
    logic           from_fresh, from_again;

    fresh_head_d   = fresh_head_q;
    fresh_count_d  = fresh_count_q;
    again_head_d   = again_head_q;
    again_count_d  = again_count_q;
    cpu_busy_d     = cpu_busy_q;
    cpu_id_d       = cpu_id_q;
    cpu_left_d     = cpu_left_q;
    cpu_response_d = cpu_response_q;
    slice_left_d   = slice_left_q;
    now_time_d     = now_time_q;
    overhead_acc_d = overhead_acc_q;
    response_acc_d = response_acc_q;
    finished_acc_d = finished_acc_q;
    fresh_we       = 1'b0;
    again_we       = 1'b0;
    from_fresh     = 1'b0;
    from_again     = 1'b0;
    ts             = (quantum_q == 8'd0) ? 8'd1 : quantum_q;
    used           = (CNT_W+1)'(fresh_count_q) + (CNT_W+1)'(again_count_q)
                   + (CNT_W+1)'(cpu_busy_q);

    res           = '0;
    res.tick_time = now_time_q;

    if (in_fire) begin
      if (rrts_pkg::kind_e'(kind_i) == rrts_pkg::KIND_ARRIVAL) begin
        if (used >= (CNT_W+1)'(DEPTH) || work_ticks_i == 16'd0) begin
          res.status = rrts_pkg::ST_REJECTED;
        end else begin
          fresh_we      = 1'b1;
          fresh_count_d = fresh_count_q + 1'b1;
          res.status    = rrts_pkg::ST_ACCEPTED;
        end
      end else begin
        if (cpu_busy_q) begin
          if (cpu_left_q == 16'd0) begin
            res.retired_valid    = 1'b1;
            res.retired_id       = cpu_id_q;
            res.retired_response = cpu_response_q;
            response_acc_d       = sat_add(response_acc_q, cpu_response_q);
            if (finished_acc_q != 16'hFFFF) begin
              finished_acc_d = finished_acc_q + 1'b1;
            end
            cpu_busy_d = 1'b0;
          end else if (slice_left_q == 8'd0 && again_count_q < CNT_W'(DEPTH)) begin
            again_we      = 1'b1;
            again_count_d = again_count_q + 1'b1;
            cpu_busy_d    = 1'b0;
          end
        end

        if (!cpu_busy_d) begin
          if (fresh_count_q != '0) begin
            from_fresh     = 1'b1;
            cpu_id_d       = fresh_ids_q[fresh_head_q];
            cpu_left_d     = fresh_remaining_q[fresh_head_q];
            cpu_response_d = now_time_q - fresh_arrival_q[fresh_head_q];
            fresh_head_d   = ptr_inc(fresh_head_q);
            fresh_count_d  = fresh_count_q - 1'b1;
          end else if (again_count_d != '0) begin
            from_again = 1'b1;
            // the task just preempted is the only one queued
            if (again_count_q == '0) begin
              cpu_id_d       = cpu_id_q;
              cpu_left_d     = cpu_left_q;
              cpu_response_d = cpu_response_q;
            end else begin
              cpu_id_d       = again_ids_q[again_head_q];
              cpu_left_d     = again_remaining_q[again_head_q];
              cpu_response_d = again_response_q[again_head_q];
            end
            again_head_d  = ptr_inc(again_head_q);
            again_count_d = again_count_d - 1'b1;
          end
          if (from_fresh || from_again) begin
            cpu_busy_d     = 1'b1;
            slice_left_d   = (cpu_left_d < {8'd0, ts}) ? cpu_left_d[7:0] : ts;
            overhead_acc_d = sat_add(overhead_acc_q, {24'd0, switch_overhead_q});
          end
        end

        if (cpu_busy_d) begin
          if (cpu_left_d != 16'd0) begin
            cpu_left_d = cpu_left_d - 1'b1;
          end
          if (slice_left_d != 8'd0) begin
            slice_left_d = slice_left_d - 1'b1;
          end
          res.running_id   = cpu_id_d;
          res.running_left = cpu_left_d;
          res.running_done = (cpu_left_d == 16'd0);
          res.status       = rrts_pkg::ST_RAN;
        end else begin
          res.status = rrts_pkg::ST_IDLE;
        end
        now_time_d = now_time_q + 32'd1;
      end
    end

    res.overhead_sum   = overhead_acc_d;
    res.response_total = response_acc_d;
    res.finished_count = finished_acc_d;
    res.all_idle       = (fresh_count_d == '0) && (again_count_d == '0) && !cpu_busy_d;
  end

  // queue entries
  always_ff @(posedge clk_i) begin
    if (fresh_we) begin
      fresh_ids_q[fresh_tail]       <= task_id_i;
      fresh_remaining_q[fresh_tail] <= work_ticks_i;
      fresh_arrival_q[fresh_tail]   <= now_time_q;
    end
    if (again_we) begin
      again_ids_q[again_tail]       <= cpu_id_q;
      again_remaining_q[again_tail] <= cpu_left_q;
      again_response_q[again_tail]  <= cpu_response_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_head_q   <= '0;
      fresh_count_q  <= '0;
      again_head_q   <= '0;
      again_count_q  <= '0;
      cpu_busy_q     <= 1'b0;
      cpu_id_q       <= '0;
      cpu_left_q     <= '0;
      cpu_response_q <= '0;
      slice_left_q   <= '0;
      now_time_q     <= '0;
      overhead_acc_q <= '0;
      response_acc_q <= '0;
      finished_acc_q <= '0;
    end else begin
      fresh_head_q   <= fresh_head_d;
      fresh_count_q  <= fresh_count_d;
      again_head_q   <= again_head_d;
      again_count_q  <= again_count_d;
      cpu_busy_q     <= cpu_busy_d;
      cpu_id_q       <= cpu_id_d;
      cpu_left_q     <= cpu_left_d;
      cpu_response_q <= cpu_response_d;
      slice_left_q   <= slice_left_d;
      now_time_q     <= now_time_d;
      overhead_acc_q <= overhead_acc_d;
      response_acc_q <= response_acc_d;
      finished_acc_q <= finished_acc_d;
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_q.status;
  assign tick_time_o        = out_q.tick_time;
  assign running_id_o       = out_q.running_id;
  assign running_left_o     = out_q.running_left;
  assign running_done_o     = out_q.running_done;
  assign retired_valid_o    = out_q.retired_valid;
  assign retired_id_o       = out_q.retired_id;
  assign retired_response_o = out_q.retired_response;
  assign overhead_sum_o     = out_q.overhead_sum;
  assign response_total_o   = out_q.response_total;
  assign finished_count_o   = out_q.finished_count;
  assign all_idle_o         = out_q.all_idle;

endmodule

// File: rtl/core/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// port-level checks on the result channel of the task scheduler
// ----------------------------------------------------------------------------
`include "round_robin_task_scheduler_unit_assert.svh"

module rrts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [31:0] tick_time_o,
  input logic [15:0] running_id_o,
  input logic [15:0] running_left_o,
  input logic        running_done_o,
  input logic        retired_valid_o,
  input logic        all_idle_o
);

  `RRTS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(tick_time_o))

  `RRTS_ASSERT_NOW(a_no_run_fields, out_valid_o && status_o != rrts_pkg::ST_RAN, running_id_o == 16'd0 && running_left_o == 16'd0 && !running_done_o)

  `RRTS_ASSERT_NOW(a_retire_on_tick, out_valid_o && retired_valid_o, status_o == rrts_pkg::ST_RAN || status_o == rrts_pkg::ST_IDLE)

  `RRTS_ASSERT_NOW(a_done_matches, out_valid_o && status_o == rrts_pkg::ST_RAN, running_done_o == (running_left_o == 16'd0))

  `RRTS_ASSERT_NOW(a_busy_not_idle, out_valid_o && status_o == rrts_pkg::ST_RAN && !running_done_o, !all_idle_o)

endmodule

bind round_robin_task_scheduler_unit rrts_checker u_rrts_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the round robin task scheduler against a cycle-free scheduling model:
// arrivals and ticks go in through a gapped driver, results are compared field
// by field with predicted ones, across several time slice and overhead settings
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    rrts_pkg::kind_e kind;
    logic [15:0]     task_id;
    logic [15:0]     service;
  } job_t;

  logic            clk_i = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  rrts_pkg::kind_e in_kind = rrts_pkg::KIND_ARRIVAL;
  logic [15:0]     in_task_id = '0;
  logic [15:0]     in_service = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  rrts_pkg::res_t  got;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [rrts_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;
  logic [1:0]      status_raw;

  job_t           backlog[$];
  rrts_pkg::res_t outstanding[$];
  int unsigned    errors = 0;
  int unsigned    cycles = 0;
  int unsigned    send_gap = 0;
  int unsigned    hold_cnt = 0;
  bit             no_idle = 1'b0;

  // scheduler model state
  logic [7:0]  cfg_slice = rrts_pkg::QUANTUM_RST;
  logic [7:0]  cfg_ovh = 8'd0;
  logic [15:0] fq_id[rrts_pkg::QUEUE_DEPTH];
  logic [15:0] fq_left[rrts_pkg::QUEUE_DEPTH];
  logic [31:0] fq_arr[rrts_pkg::QUEUE_DEPTH];
  int unsigned fq_head = 0;
  int unsigned fq_cnt = 0;
  logic [15:0] rq_id[rrts_pkg::QUEUE_DEPTH];
  logic [15:0] rq_left[rrts_pkg::QUEUE_DEPTH];
  logic [31:0] rq_resp[rrts_pkg::QUEUE_DEPTH];
  int unsigned rq_head = 0;
  int unsigned rq_cnt = 0;
  bit          cpu_on = 1'b0;
  logic [15:0] cpu_task = '0;
  logic [15:0] cpu_rem = '0;
  logic [31:0] cpu_resp = '0;
  logic [7:0]  slice_rem = '0;
  logic [31:0] clock_now = '0;
  logic [31:0] ovh_acc = '0;
  logic [31:0] resp_acc = '0;
  logic [15:0] done_acc = '0;

  always #2 clk_i = ~clk_i;

  round_robin_task_scheduler_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .kind_i             (in_kind),
    .task_id_i          (in_task_id),
    .work_ticks_i       (in_service),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .status_o           (status_raw),
    .tick_time_o        (got.tick_time),
    .running_id_o       (got.running_id),
    .running_left_o     (got.running_left),
    .running_done_o     (got.running_done),
    .retired_valid_o    (got.retired_valid),
    .retired_id_o       (got.retired_id),
    .retired_response_o (got.retired_response),
    .overhead_sum_o     (got.overhead_sum),
    .response_total_o   (got.response_total),
    .finished_count_o   (got.finished_count),
    .all_idle_o         (got.all_idle),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  assign got.status = rrts_pkg::status_e'(status_raw);

  function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void start_task(logic [15:0] left, logic [31:0] resp);
    logic [15:0] ts;
    ts = (cfg_slice == 8'd0) ? 16'd1 : {8'd0, cfg_slice};
    cpu_on = 1'b1;
    cpu_rem = left;
    cpu_resp = resp;
    slice_rem = (left < ts) ? left[7:0] : ts[7:0];
    ovh_acc = sat32(ovh_acc, {24'd0, cfg_ovh});
  endfunction

  function automatic rrts_pkg::res_t schedule_item(rrts_pkg::kind_e k, logic [15:0] id,
                                                   logic [15:0] serv);
    rrts_pkg::res_t r;
    int unsigned slot;
    r = '0;
    r.tick_time = clock_now;
    if (k == rrts_pkg::KIND_ARRIVAL) begin
      if (fq_cnt + rq_cnt + cpu_on >= rrts_pkg::QUEUE_DEPTH || serv == 16'd0) begin
        r.status = rrts_pkg::ST_REJECTED;
      end else begin
        slot = (fq_head + fq_cnt) % rrts_pkg::QUEUE_DEPTH;
        fq_id[slot] = id;
        fq_left[slot] = serv;
        fq_arr[slot] = clock_now;
        fq_cnt++;
        r.status = rrts_pkg::ST_ACCEPTED;
      end
    end else begin
      if (cpu_on) begin
        if (cpu_rem == 16'd0) begin
          r.retired_valid = 1'b1;
          r.retired_id = cpu_task;
          r.retired_response = cpu_resp;
          resp_acc = sat32(resp_acc, cpu_resp);
          if (done_acc != 16'hFFFF) done_acc++;
          cpu_on = 1'b0;
        end else if (slice_rem == 8'd0) begin
          slot = (rq_head + rq_cnt) % rrts_pkg::QUEUE_DEPTH;
          rq_id[slot] = cpu_task;
          rq_left[slot] = cpu_rem;
          rq_resp[slot] = cpu_resp;
          rq_cnt++;
          cpu_on = 1'b0;
        end
      end
      if (!cpu_on) begin
        if (fq_cnt > 0) begin
          cpu_task = fq_id[fq_head];
          start_task(fq_left[fq_head], clock_now - fq_arr[fq_head]);
          fq_head = (fq_head + 1) % rrts_pkg::QUEUE_DEPTH;
          fq_cnt--;
        end else if (rq_cnt > 0) begin
          cpu_task = rq_id[rq_head];
          start_task(rq_left[rq_head], rq_resp[rq_head]);
          rq_head = (rq_head + 1) % rrts_pkg::QUEUE_DEPTH;
          rq_cnt--;
        end
      end
      if (cpu_on) begin
        if (cpu_rem != 16'd0) cpu_rem--;
        if (slice_rem != 8'd0) slice_rem--;
        r.running_id = cpu_task;
        r.running_left = cpu_rem;
        r.running_done = (cpu_rem == 16'd0);
        r.status = rrts_pkg::ST_RAN;
      end else begin
        r.status = rrts_pkg::ST_IDLE;
      end
      clock_now = clock_now + 32'd1;
    end
    r.overhead_sum = ovh_acc;
    r.response_total = resp_acc;
    r.finished_count = done_acc;
    r.all_idle = (fq_cnt == 0 && rq_cnt == 0 && !cpu_on);
    return r;
  endfunction

  function automatic int unsigned pick_wait();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, seen, want);
  endtask

  task automatic check_result(rrts_pkg::res_t seen);
    rrts_pkg::res_t want;
    if (outstanding.size() == 0) begin
      report_mismatch("item with nothing expected, tick_time", seen.tick_time, '0);
      return;
    end
    want = outstanding.pop_front();
    if (seen.status !== want.status)
      report_mismatch("status", seen.status, want.status);
    if (seen.tick_time !== want.tick_time)
      report_mismatch("tick_time", seen.tick_time, want.tick_time);
    if (seen.running_id !== want.running_id)
      report_mismatch("running_id", seen.running_id, want.running_id);
    if (seen.running_left !== want.running_left)
      report_mismatch("running_left", seen.running_left, want.running_left);
    if (seen.running_done !== want.running_done)
      report_mismatch("running_done", seen.running_done, want.running_done);
    if (seen.retired_valid !== want.retired_valid)
      report_mismatch("retired_valid", seen.retired_valid, want.retired_valid);
    if (seen.retired_id !== want.retired_id)
      report_mismatch("retired_id", seen.retired_id, want.retired_id);
    if (seen.retired_response !== want.retired_response)
      report_mismatch("retired_response", seen.retired_response, want.retired_response);
    if (seen.overhead_sum !== want.overhead_sum)
      report_mismatch("overhead_sum", seen.overhead_sum, want.overhead_sum);
    if (seen.response_total !== want.response_total)
      report_mismatch("response_total", seen.response_total, want.response_total);
    if (seen.finished_count !== want.finished_count)
      report_mismatch("finished_count", seen.finished_count, want.finished_count);
    if (seen.all_idle !== want.all_idle)
      report_mismatch("all_idle", seen.all_idle, want.all_idle);
  endtask

  // driver: predicts each accepted item, then presents the next one
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        outstanding.push_back(schedule_item(in_kind, in_task_id, in_service));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (backlog.size() > 0) begin
          in_kind <= backlog[0].kind;
          in_task_id <= backlog[0].task_id;
          in_service <= backlog[0].service;
          in_valid <= 1'b1;
          void'(backlog.pop_front());
          send_gap = pick_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        check_result(got);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        hold_cnt = pick_wait();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_job(rrts_pkg::kind_e k, logic [15:0] id, logic [15:0] serv);
    backlog.push_back('{kind: k, task_id: id, service: serv});
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (backlog.size() != 0 || in_valid || outstanding.size() != 0);
  endtask

  task automatic write_reg(rrts_pkg::reg_e r, logic [7:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rrts_pkg::ADDR_W'(int'(r) * 4);
    pwdata <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (r == rrts_pkg::REG_QUANTUM) cfg_slice = v;
    else cfg_ovh = v;
  endtask

  task automatic set_regs(logic [7:0] ts, logic [7:0] oh);
    write_reg(rrts_pkg::REG_QUANTUM, ts);
    write_reg(rrts_pkg::REG_SWITCH_OVERHEAD, oh);
  endtask

  // fills every free slot, then offers arrivals that must bounce off the full system
  task automatic fill_capacity();
    int unsigned room;
    room = rrts_pkg::QUEUE_DEPTH - (fq_cnt + rq_cnt + cpu_on);
    repeat (room)
      push_job(rrts_pkg::KIND_ARRIVAL, 16'($urandom()), 16'($urandom_range(1, 6)));
    repeat (6) push_job(rrts_pkg::KIND_ARRIVAL, 16'($urandom()), 16'($urandom()));
  endtask

  task automatic random_items(int unsigned n, int unsigned tick_pct);
    job_t j;
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      j.task_id = 16'($urandom());
      j.service = 16'($urandom());
      if ($urandom_range(0, 99) < tick_pct) begin
        j.kind = rrts_pkg::KIND_TICK;
      end else begin
        j.kind = rrts_pkg::KIND_ARRIVAL;
        r = $urandom_range(0, 99);
        if (r < 6) j.service = '0;
        else if (r < 80) j.service = 16'($urandom_range(1, 8));
        else j.service = 16'($urandom_range(9, 40));
      end
      backlog.push_back(j);
    end
  endtask

  task automatic directed_items();
    push_job(rrts_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF);
    push_job(rrts_pkg::KIND_ARRIVAL, 16'h0000, 16'h0000);
    push_job(rrts_pkg::KIND_ARRIVAL, 16'hFFFF, 16'h0000);
    push_job(rrts_pkg::KIND_ARRIVAL, 16'hFFFF, 16'h0001);
    push_job(rrts_pkg::KIND_ARRIVAL, 16'h0000, 16'h0006);
    push_job(rrts_pkg::KIND_ARRIVAL, 16'h1234, 16'h0002);
    push_job(rrts_pkg::KIND_TICK, 16'h0000, 16'h0000);
    push_job(rrts_pkg::KIND_TICK, 16'h5A5A, 16'hA5A5);
    push_job(rrts_pkg::KIND_ARRIVAL, 16'h00AA, 16'h0003);
    repeat (12) push_job(rrts_pkg::KIND_TICK, 16'($urandom()), 16'($urandom()));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);
    directed_items();
    wait_drained();
    set_regs(8'd1, 8'd255);
    fill_capacity();
    random_items(110, 50);
    wait_drained();
    set_regs(8'd255, 8'd0);
    random_items(110, 55);
    wait_drained();
    set_regs(8'd0, 8'd17);
    fill_capacity();
    random_items(110, 50);
    wait_drained();
    no_idle = 1'b1;
    set_regs(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
    random_items(100, 50);
    wait_drained();
    no_idle = 1'b0;
    set_regs(8'($urandom_range(1, 12)), 8'($urandom_range(0, 255)));
    fill_capacity();
    random_items(100, 45);
    wait_drained();
    set_regs(8'd3, 8'd255);
    random_items(70, 90);
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: round_robin_task_scheduler_unit.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/round_robin_task_scheduler_unit.sv
rtl/core/rrts_checker.sv
test/tb_top.sv
